// File: sv/psfe_pkg.sv
// ----------------------------------------------------------------------------
// psfe_pkg
// types, constants and float helpers shared by the frame encoder modules
// ----------------------------------------------------------------------------
package psfe_pkg;

  localparam int CodeW  = 12;
  localparam int FrameLen = 14;

  typedef struct packed {
    logic [CodeW-1:0] voltage_code;
    logic [CodeW-1:0] current_code;
  } sample_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } frame_out_t;

  // converted sample waiting in the queue
  typedef struct packed {
    logic [31:0] volt;
    logic [31:0] curr;
  } qentry_t;

  // computed values handed to the serializer
  typedef struct packed {
    logic        valid;
    logic [31:0] curr;
    logic [31:0] volt;
    logic [31:0] pwr;
  } result_t;

  localparam logic [7:0]  FrameHead = 8'hAB;
  localparam logic [31:0] K4096  = 32'h4580_0000;
  localparam logic [31:0] K3p3   = 32'h4053_3333;
  localparam logic [31:0] K50    = 32'h4248_0000;
  localparam logic [31:0] K10010 = 32'h461C_6800;
  localparam logic [31:0] K10    = 32'h4120_0000;
  localparam logic [31:0] K0p005 = 32'h3BA3_D70A;
  localparam logic [11:0] Midscale = 12'd2048;

  // floor(2^50 / divisor significand) for each constant divisor
  localparam logic [63:0] RcpScale = 64'd1 << 50;
  localparam logic [27:0] Rcp4096  = 28'(RcpScale / {40'd0, 1'b1, K4096[22:0]});
  localparam logic [27:0] Rcp50    = 28'(RcpScale / {40'd0, 1'b1, K50[22:0]});
  localparam logic [27:0] Rcp10    = 28'(RcpScale / {40'd0, 1'b1, K10[22:0]});
  localparam logic [27:0] Rcp0p005 = 28'(RcpScale / {40'd0, 1'b1, K0p005[22:0]});

  // exact conversion of a sign-magnitude integer below 4096
  function automatic logic [31:0] int_to_float(input logic sgn, input logic [11:0] mag);
    logic [3:0]  msb;
    logic [23:0] sh;
    logic [31:0] res;
    msb = 4'd0;
    for (int i = 0; i < 12; i++) begin
      if (mag[i]) msb = 4'(i);
    end
    sh = {12'd0, mag} << (5'd23 - {1'b0, msb});
    if (mag == 12'd0) res = 32'd0;
    else res = {sgn, 8'(8'd127 + {4'd0, msb}), sh[22:0]};
    return res;
  endfunction

endpackage

// File: sv/psfe_front.sv
// ----------------------------------------------------------------------------
// psfe_front
// accepts adc code pairs, converts them to float and queues them
// ----------------------------------------------------------------------------
module psfe_front import psfe_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  sample_t in_item,
  output logic    q_valid,
  input  logic    q_pop,
  output qentry_t q_head
);

  qentry_t    slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       cneg;
  logic [11:0] cmag;
  qentry_t    conv;

  always_comb begin
    cneg = in_item.current_code < Midscale;
    cmag = cneg ? (Midscale - in_item.current_code) : (in_item.current_code - Midscale);
    conv.volt = int_to_float(1'b0, in_item.voltage_code);
    conv.curr = int_to_float(cneg, cmag);
  end

  assign in_ready = count != 2'd2;
  assign push     = in_valid && in_ready;
  assign q_valid  = count != 2'd0;
  assign q_head   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= conv;
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

// File: sv/psfe_engine.sv
// ----------------------------------------------------------------------------
// psfe_engine
// runs the fixed float chain on one shared multiply / divide unit
// ----------------------------------------------------------------------------
module psfe_engine import psfe_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    q_valid,
  output logic    q_pop,
  input  qentry_t q_head,
  output result_t res,
  input  logic    res_ready
);

  typedef enum logic [2:0] {S_IDLE, S_ISSUE, S_DIV, S_FIX, S_ADJ, S_RND, S_DONE} state_t;

  localparam logic [3:0] LastStep = 4'd9;

  state_t      state;
  logic [3:0]  step;
  logic [31:0] volt, curr, pwr;
  logic        rsign, rzero, is_div;
  logic signed [9:0] rexp;
  logic [47:0] prod;
  logic [25:0] rem;
  logic [24:0] quo;
  logic [23:0] dvsr;
  logic [24:0] num;
  logic [27:0] rcp;

  // operand selection
  logic [31:0] opa, opb;
  logic        op_div;
  logic [27:0] rcp_sel;
  logic [23:0] ma, mb;
  logic signed [9:0] ea, eb;
  always_comb begin
    opa = volt; opb = K4096; op_div = 1'b1; rcp_sel = Rcp4096;
    case (step)
      4'd0: begin opa = volt; opb = K4096;  op_div = 1'b1; rcp_sel = Rcp4096;  end
      4'd1: begin opa = volt; opb = K3p3;   op_div = 1'b0; rcp_sel = Rcp4096;  end
      4'd2: begin opa = volt; opb = K50;    op_div = 1'b1; rcp_sel = Rcp50;    end
      4'd3: begin opa = volt; opb = K10010; op_div = 1'b0; rcp_sel = Rcp4096;  end
      4'd4: begin opa = volt; opb = K10;    op_div = 1'b1; rcp_sel = Rcp10;    end
      4'd5: begin opa = curr; opb = K4096;  op_div = 1'b1; rcp_sel = Rcp4096;  end
      4'd6: begin opa = curr; opb = K3p3;   op_div = 1'b0; rcp_sel = Rcp4096;  end
      4'd7: begin opa = curr; opb = K50;    op_div = 1'b1; rcp_sel = Rcp50;    end
      4'd8: begin opa = curr; opb = K0p005; op_div = 1'b1; rcp_sel = Rcp0p005; end
      default: begin opa = volt; opb = curr; op_div = 1'b0; rcp_sel = Rcp4096; end
    endcase
    ma = {1'b1, opa[22:0]};
    mb = {1'b1, opb[22:0]};
    ea = $signed({2'b00, opa[30:23]});
    eb = $signed({2'b00, opb[30:23]});
  end

  // constant divide: reciprocal estimate (low by at most one), then remainder
  logic [52:0] qmul;
  logic [48:0] qd;
  logic [48:0] rdiff;
  always_comb begin
    qmul  = {28'd0, num} * {25'd0, rcp};
    qd    = {24'd0, quo} * {25'd0, dvsr};
    rdiff = {num, 24'd0} - qd;
  end

  // normalize and round to nearest even
  logic [23:0] nm;
  logic        ng, ns;
  logic signed [9:0] ne;
  logic [24:0] rsum;
  logic [31:0] rbits;
  always_comb begin
    if (is_div) begin
      nm = quo[24:1]; ng = quo[0]; ns = rem != 26'd0; ne = rexp;
    end else if (prod[47]) begin
      nm = prod[47:24]; ng = prod[23]; ns = |prod[22:0]; ne = rexp + 10'sd1;
    end else begin
      nm = prod[46:23]; ng = prod[22]; ns = |prod[21:0]; ne = rexp;
    end
    rsum = {1'b0, nm} + {24'd0, ng & (ns | nm[0])};
    if (rsum[24]) ne = ne + 10'sd1;
    if (rzero) rbits = {rsign, 31'd0};
    else rbits = {rsign, ne[7:0], rsum[24] ? rsum[23:1] : rsum[22:0]};
  end

  assign q_pop     = state == S_IDLE && q_valid;
  assign res.valid = state == S_DONE;
  assign res.curr  = curr;
  assign res.volt  = volt;
  assign res.pwr   = pwr;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= 4'd0;
    end else begin
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            volt  <= q_head.volt;
            curr  <= q_head.curr;
            step  <= 4'd0;
            state <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          is_div <= op_div;
          rsign  <= opa[31] ^ opb[31];
          rzero  <= opa[30:0] == 31'd0 || (!op_div && opb[30:0] == 31'd0);
          if (op_div) begin
            dvsr <= mb;
            rcp  <= rcp_sel;
            if (ma >= mb) begin
              num  <= {1'b0, ma};
              rexp <= ea - eb + 10'sd127;
            end else begin
              num  <= {ma, 1'b0};
              rexp <= ea - eb + 10'sd126;
            end
            state <= S_DIV;
          end else begin
            prod  <= ma * mb;
            rexp  <= ea + eb - 10'sd127;
            state <= S_RND;
          end
        end
        S_DIV: begin
          quo   <= qmul[50:26];
          state <= S_FIX;
        end
        S_FIX: begin
          rem   <= rdiff[25:0];
          state <= S_ADJ;
        end
        S_ADJ: begin
          if (rem >= {2'b00, dvsr}) begin
            quo <= quo + 25'd1;
            rem <= rem - {2'b00, dvsr};
          end
          state <= S_RND;
        end
        S_RND: begin
          if (step <= 4'd4) volt <= rbits;
          else if (step < LastStep) curr <= rbits;
          else pwr <= rbits;
          if (step == LastStep) state <= S_DONE;
          else begin
            step  <= step + 4'd1;
            state <= S_ISSUE;
          end
        end
        S_DONE: begin
          if (res_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: sv/psfe_serializer.sv
// ----------------------------------------------------------------------------
// psfe_serializer
// streams the 14-byte frame with a running checksum
// ----------------------------------------------------------------------------
module psfe_serializer import psfe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  result_t    res,
  output logic       res_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output frame_out_t out_item
);

  localparam logic [3:0] LastIdx = 4'(FrameLen - 1);

  logic        busy;
  logic [3:0]  idx;
  logic [31:0] curr, volt, pwr;
  logic [7:0]  sum;
  logic [7:0]  cur_byte;

  always_comb begin
    case (idx)
      4'd0:  cur_byte = FrameHead;
      4'd1:  cur_byte = curr[7:0];
      4'd2:  cur_byte = curr[15:8];
      4'd3:  cur_byte = curr[23:16];
      4'd4:  cur_byte = curr[31:24];
      4'd5:  cur_byte = volt[7:0];
      4'd6:  cur_byte = volt[15:8];
      4'd7:  cur_byte = volt[23:16];
      4'd8:  cur_byte = volt[31:24];
      4'd9:  cur_byte = pwr[7:0];
      4'd10: cur_byte = pwr[15:8];
      4'd11: cur_byte = pwr[23:16];
      4'd12: cur_byte = pwr[31:24];
      default: cur_byte = sum;
    endcase
  end

  assign res_ready           = !busy;
  assign out_valid           = busy;
  assign out_item.frame_byte = cur_byte;
  assign out_item.last_byte  = idx == LastIdx;

  always_ff @(posedge clk) begin
    if (res.valid && !busy) begin
      curr <= res.curr;
      volt <= res.volt;
      pwr  <= res.pwr;
    end
    if (rst) begin
      busy <= 1'b0;
      idx  <= 4'd0;
      sum  <= 8'd0;
    end else if (!busy) begin
      if (res.valid) begin
        busy <= 1'b1;
        idx  <= 4'd0;
        sum  <= 8'd0;
      end
    end else if (out_ready) begin
      if (idx != 4'd0 && idx != LastIdx) sum <= sum + cur_byte;
      if (idx == LastIdx) busy <= 1'b0;
      else idx <= idx + 4'd1;
    end
  end

endmodule

// File: sv/power_sample_frame_encoder_core.sv
// ----------------------------------------------------------------------------
// power_sample_frame_encoder_core
// adc sample pair to float telemetry frame encoder
// ----------------------------------------------------------------------------
// each accepted transfer carries a voltage and a current adc code; the block
// turns them into single precision voltage, current and power (every step
// rounded to nearest even, in fixed order) and sends a 14-byte frame: header
// 0xab, current, voltage and power little-endian, then the byte sum of the
// twelve payload bytes. one multiply unit works the ten float steps: a divide
// by one of the constant divisors is a reciprocal multiply, a remainder and a
// one-step correction, then rounding, and a multiply is an issue then a
// rounding; the result is held until the serializer is free to take it. the
// frame then leaves at one byte per cycle while out_ready is high. a two-entry
// queue in front and the frame register behind let a new sample be taken and
// worked on while the previous frame is still being sent.
module power_sample_frame_encoder_core import psfe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  sample_t    in_item,
  output logic       out_valid,
  input  logic       out_ready,
  output frame_out_t out_item
);

  // front to engine queue
  logic    q_valid;
  logic    q_pop;
  qentry_t q_head;

  // engine to serializer handoff
  result_t res;
  logic    res_ready;

  // code conversion and queue
  psfe_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_head   (q_head)
  );

  // float chain
  psfe_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_head    (q_head),
    .res       (res),
    .res_ready (res_ready)
  );

  // frame output
  psfe_serializer u_ser (
    .clk       (clk),
    .rst       (rst),
    .res       (res),
    .res_ready (res_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
